// ===== design/vlpc_pkg.sv =====
// ---------------------------------------------------------------------------
// vlpc_pkg: shared types and constants for the versioned LRU placement cache
// Request and entry layouts, status codes, request kinds, back-end states.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package vlpc_pkg;

    localparam int DEFAULT_ENTRIES = 16;
    localparam int KEY_W           = 64;
    localparam int FRAME_W         = 32;
    localparam int CNT32_W         = 32;
    localparam int STATUS_W        = 3;
    localparam int SLOT_W          = 4;
    localparam int FILL_OUT_W      = 5;
    localparam int CAP_W           = 5;
    localparam int PADDR_W         = 3;
    localparam int PDATA_W         = 32;
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    // Register index of capacity (byte address 4 * index)
    localparam logic REG_CAPACITY = 1'b0;

    typedef enum logic [STATUS_W-1:0] {
        ST_REJECT = 3'd0,
        ST_HIT    = 3'd1,
        ST_INSERT = 3'd2,
        ST_UPDATE = 3'd3,
        ST_CLEAR  = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        KIND_REJECT  = 2'd0,
        KIND_RESOLVE = 2'd1,
        KIND_CLEAR   = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        BK_IDLE = 2'd0,
        BK_SCAN = 2'd1,
        BK_DONE = 2'd2
    } back_state_t;

    typedef struct packed {
        kind_t              kind;
        logic [KEY_W-1:0]   identity;
        logic [KEY_W-1:0]   transform;
        logic [KEY_W-1:0]   content;
        logic [FRAME_W-1:0] frame;
    } req_t;

    typedef struct packed {
        logic [KEY_W-1:0]   identity;
        logic [KEY_W-1:0]   transform;
        logic [KEY_W-1:0]   content;
        logic [FRAME_W-1:0] frame;
    } entry_t;

    typedef struct packed {
        status_t               status;
        logic [SLOT_W-1:0]     slot;
        logic                  evicted;
        logic [FILL_OUT_W-1:0] entry_count;
        logic [CNT32_W-1:0]    hit_count;
        logic [CNT32_W-1:0]    miss_count;
        logic [CNT32_W-1:0]    update_count;
        logic [CNT32_W-1:0]    eviction_count;
    } result_t;

    // Saturating increment of a statistics counter
    function automatic logic [CNT32_W-1:0] sat_inc(input logic [CNT32_W-1:0] x);
        logic [CNT32_W-1:0] r;
        r = (x == '1) ? x : x + 1'b1;
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== design/versioned_lru_placement_cache.sv =====
// ---------------------------------------------------------------------------
// versioned_lru_placement_cache: fully associative versioned LRU cache
// Usage:
//   Input channel (in_valid / in_stall) carries one request word: a resolve
//   (mode 0) or a table clear (mode 1). Output channel (out_valid /
//   out_stall) returns exactly one result word per request, in order.
//   A two-word queue sits between intake and the table walk, so requests
//   are taken while a result still waits in the output register.
//   A resolve walks the entry RAM one entry per cycle over its single read
//   port; clear and rejected requests skip the walk. The back end takes
//   the next request from the queue only once the current result is loaded.
//   Capacity sits at byte address 0 of the APB port; write it only while
//   the block is idle.
//   Reset empties the table, zeroes all counters and sets capacity to 16.
//   The entry RAM itself is not cleared; valid bits guard it.
//   While out_stall is high the result word holds, the walk finishes into
//   the waiting state, and in_stall rises once the queue fills.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module versioned_lru_placement_cache #(
    parameter int ENTRIES = vlpc_pkg::DEFAULT_ENTRIES
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [vlpc_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [vlpc_pkg::PDATA_W-1:0]  pwdata,
    output logic      [vlpc_pkg::PDATA_W-1:0]  prdata,
    output logic                               pready,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic                          mode,
    input  wire logic [vlpc_pkg::KEY_W-1:0]    identity,
    input  wire logic [vlpc_pkg::KEY_W-1:0]    transform_version,
    input  wire logic [vlpc_pkg::KEY_W-1:0]    content_version,
    input  wire logic [vlpc_pkg::FRAME_W-1:0]  frame_number,
    input  wire logic                          has_anchors,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic [vlpc_pkg::STATUS_W-1:0]      status,
    output logic [vlpc_pkg::SLOT_W-1:0]        slot,
    output logic                               evicted,
    output logic [vlpc_pkg::FILL_OUT_W-1:0]    entry_count,
    output logic [vlpc_pkg::CNT32_W-1:0]       hit_count,
    output logic [vlpc_pkg::CNT32_W-1:0]       miss_count,
    output logic [vlpc_pkg::CNT32_W-1:0]       update_count,
    output logic [vlpc_pkg::CNT32_W-1:0]       eviction_count
);
    import vlpc_pkg::*;

    logic [CAP_W-1:0] capacity_reg;
    logic             q_valid;
    logic             q_pop;
    req_t             q_item;
    result_t          result;

    // Configuration register
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_CAPACITY) ? PDATA_W'(capacity_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= CAP_RESET;
        end
        else if (psel && penable && pwrite && pready && paddr[2] == REG_CAPACITY)
        begin
            capacity_reg <= pwdata[CAP_W-1:0];
        end
    end

    vlpc_front u_front (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .mode              (mode),
        .identity          (identity),
        .transform_version (transform_version),
        .content_version   (content_version),
        .frame_number      (frame_number),
        .has_anchors       (has_anchors),
        .q_valid           (q_valid),
        .q_item            (q_item),
        .q_pop             (q_pop)
    );

    vlpc_back #(
        .ENTRIES (ENTRIES)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .capacity  (capacity_reg),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .result    (result)
    );

    // Unpack the result word
    assign status         = result.status;
    assign slot           = result.slot;
    assign evicted        = result.evicted;
    assign entry_count    = result.entry_count;
    assign hit_count      = result.hit_count;
    assign miss_count     = result.miss_count;
    assign update_count   = result.update_count;
    assign eviction_count = result.eviction_count;

endmodule

`default_nettype wire

// ===== design/vlpc_ram.sv =====
// ---------------------------------------------------------------------------
// vlpc_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module vlpc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                  clk,
    input  wire logic                                  wr_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]                      wr_data,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic      [WIDTH-1:0]                      rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

// ===== design/vlpc_front.sv =====
// ---------------------------------------------------------------------------
// vlpc_front: request intake and classification
// Accepts request words, classifies them, and queues them for the back end.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module vlpc_front (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     in_valid,
    output logic                          in_stall,
    input  wire logic                     mode,
    input  wire logic [vlpc_pkg::KEY_W-1:0]   identity,
    input  wire logic [vlpc_pkg::KEY_W-1:0]   transform_version,
    input  wire logic [vlpc_pkg::KEY_W-1:0]   content_version,
    input  wire logic [vlpc_pkg::FRAME_W-1:0] frame_number,
    input  wire logic                     has_anchors,
    output logic                          q_valid,
    output vlpc_pkg::req_t                q_item,
    input  wire logic                     q_pop
);
    import vlpc_pkg::*;

    req_t        slot_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  count_reg, count_next;
    logic        push;
    logic        pop;
    req_t        incoming;

    // Classify the incoming word
    always_comb
    begin
        incoming.identity  = identity;
        incoming.transform = transform_version;
        incoming.content   = content_version;
        incoming.frame     = frame_number;
        if (mode)
        begin
            incoming.kind = KIND_CLEAR;
        end
        else if (identity != '0 && content_version != '0 && has_anchors)
        begin
            incoming.kind = KIND_RESOLVE;
        end
        else
        begin
            incoming.kind = KIND_REJECT;
        end
    end

    assign in_stall = (count_reg == 2'd2);
    assign push     = in_valid && !in_stall;
    assign q_valid  = (count_reg != 2'd0);
    assign q_item   = slot_reg[rd_ptr_reg];
    assign pop      = q_pop && q_valid;

    // Advance queue pointers and count
    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the queued word
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= incoming;
        end
    end

endmodule

`default_nettype wire

// ===== design/vlpc_back.sv =====
// ---------------------------------------------------------------------------
// vlpc_back: table walk, replacement and statistics
// For a resolve, walks the entry RAM for key match, oldest entry and first
// free slot, then writes the entry; every request loads the result register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module vlpc_back #(
    parameter int ENTRIES = vlpc_pkg::DEFAULT_ENTRIES
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic [vlpc_pkg::CAP_W-1:0] capacity,
    input  wire logic                      q_valid,
    input  wire vlpc_pkg::req_t            q_item,
    output logic                           q_pop,
    output logic                           out_valid,
    input  wire logic                      out_stall,
    output vlpc_pkg::result_t              result
);
    import vlpc_pkg::*;

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;
    localparam int WALK_W = IDX_W + 1;

    back_state_t        state_reg, state_next;
    req_t               cur_reg;
    logic [WALK_W-1:0]  walk_reg, walk_next;
    logic               valid_reg [ENTRIES];
    logic [CNT_W-1:0]   fill_reg;
    logic [CNT32_W-1:0] hits_reg, misses_reg, updates_reg, evicts_reg;

    logic               match_found_reg, match_ceq_reg;
    logic [IDX_W-1:0]   match_idx_reg;
    logic               old_found_reg;
    logic [IDX_W-1:0]   old_idx_reg;
    logic [FRAME_W-1:0] old_frame_reg;
    logic               free_found_reg;
    logic [IDX_W-1:0]   free_idx_reg;

    logic               out_valid_reg;
    result_t            result_reg, result_next;

    entry_t             rd_entry;
    entry_t             wr_entry;
    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    logic [IDX_W-1:0]   proc_idx;
    logic               proc_en;
    logic               proc_v;
    logic               out_free;
    logic               finish;
    logic [CMP_W-1:0]   cap_eff;
    logic               full;
    logic [IDX_W-1:0]   target;
    logic               do_evict;

    vlpc_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (ENTRIES)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_entry),
        .rd_addr (walk_reg[IDX_W-1:0]),
        .rd_data (rd_entry)
    );

    assign out_free  = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;
    assign result    = result_reg;
    assign proc_en   = (state_reg == BK_SCAN) && (walk_reg != '0);
    assign proc_idx  = IDX_W'(walk_reg - 1'b1);
    assign proc_v    = valid_reg[proc_idx];
    assign finish    = (state_reg == BK_DONE) && out_free;

    // Clamp capacity to 1..ENTRIES
    always_comb
    begin
        if (capacity == '0)
        begin
            cap_eff = CMP_W'(1);
        end
        else if (CMP_W'(capacity) > CMP_W'(ENTRIES))
        begin
            cap_eff = CMP_W'(ENTRIES);
        end
        else
        begin
            cap_eff = CMP_W'(capacity);
        end
    end

    assign full     = CMP_W'(fill_reg) >= cap_eff;
    assign do_evict = !match_found_reg && full;
    assign target   = match_found_reg ? match_idx_reg :
                      (full ? old_idx_reg : free_idx_reg);

    // Entry write on a resolved request
    always_comb
    begin
        wr_en             = finish && (cur_reg.kind == KIND_RESOLVE);
        wr_addr           = target;
        wr_entry.identity  = cur_reg.identity;
        wr_entry.transform = cur_reg.transform;
        wr_entry.content   = cur_reg.content;
        wr_entry.frame     = cur_reg.frame;
    end

    // Sequencer: next state, walk counter and queue pop
    always_comb
    begin
        state_next = state_reg;
        walk_next  = walk_reg;
        q_pop      = 1'b0;
        case (state_reg)
            BK_IDLE:
            begin
                walk_next = '0;
                if (q_valid)
                begin
                    q_pop      = 1'b1;
                    state_next = (q_item.kind == KIND_RESOLVE) ? BK_SCAN : BK_DONE;
                end
            end
            BK_SCAN:
            begin
                if (walk_reg == WALK_W'(ENTRIES))
                begin
                    state_next = BK_DONE;
                end
                else
                begin
                    walk_next = walk_reg + 1'b1;
                end
            end
            BK_DONE:
            begin
                if (out_free)
                begin
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_IDLE;
            walk_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            walk_reg  <= walk_next;
        end
    end

    // Hold the current request
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            cur_reg <= q_item;
        end
    end

    // Walk: track first key match, oldest valid entry, first free slot
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_found_reg <= 1'b0;
            old_found_reg   <= 1'b0;
            free_found_reg  <= 1'b0;
        end
        else if (q_pop)
        begin
            match_found_reg <= 1'b0;
            old_found_reg   <= 1'b0;
            free_found_reg  <= 1'b0;
        end
        else if (proc_en)
        begin
            if (proc_v && !match_found_reg &&
                rd_entry.identity == cur_reg.identity &&
                rd_entry.transform == cur_reg.transform)
            begin
                match_found_reg <= 1'b1;
            end
            if (proc_v && (!old_found_reg || rd_entry.frame < old_frame_reg))
            begin
                old_found_reg <= 1'b1;
            end
            if (!proc_v && !free_found_reg)
            begin
                free_found_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (proc_en)
        begin
            if (proc_v && !match_found_reg &&
                rd_entry.identity == cur_reg.identity &&
                rd_entry.transform == cur_reg.transform)
            begin
                match_idx_reg <= proc_idx;
                match_ceq_reg <= (rd_entry.content == cur_reg.content);
            end
            if (proc_v && (!old_found_reg || rd_entry.frame < old_frame_reg))
            begin
                old_idx_reg   <= proc_idx;
                old_frame_reg <= rd_entry.frame;
            end
            if (!proc_v && !free_found_reg)
            begin
                free_idx_reg <= proc_idx;
            end
        end
    end

    // Commit: valid bits, fill, counters, result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ENTRIES; i++)
            begin
                valid_reg[i] <= 1'b0;
            end
            fill_reg      <= '0;
            hits_reg      <= '0;
            misses_reg    <= '0;
            updates_reg   <= '0;
            evicts_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            if (finish)
            begin
                case (cur_reg.kind)
                    KIND_CLEAR:
                    begin
                        for (int i = 0; i < ENTRIES; i++)
                        begin
                            valid_reg[i] <= 1'b0;
                        end
                        fill_reg    <= '0;
                        hits_reg    <= '0;
                        misses_reg  <= '0;
                        updates_reg <= '0;
                        evicts_reg  <= '0;
                    end
                    KIND_RESOLVE:
                    begin
                        if (match_found_reg && match_ceq_reg)
                        begin
                            hits_reg <= sat_inc(hits_reg);
                        end
                        else if (match_found_reg)
                        begin
                            misses_reg  <= sat_inc(misses_reg);
                            updates_reg <= sat_inc(updates_reg);
                        end
                        else
                        begin
                            misses_reg       <= sat_inc(misses_reg);
                            valid_reg[target] <= 1'b1;
                            if (do_evict)
                            begin
                                evicts_reg <= sat_inc(evicts_reg);
                            end
                            else
                            begin
                                fill_reg <= fill_reg + 1'b1;
                            end
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // Build the result word for the current request
    always_comb
    begin
        result_next.status         = ST_REJECT;
        result_next.slot           = '0;
        result_next.evicted        = 1'b0;
        result_next.entry_count    = FILL_OUT_W'(fill_reg);
        result_next.hit_count      = hits_reg;
        result_next.miss_count     = misses_reg;
        result_next.update_count   = updates_reg;
        result_next.eviction_count = evicts_reg;
        case (cur_reg.kind)
            KIND_CLEAR:
            begin
                result_next.status         = ST_CLEAR;
                result_next.entry_count    = '0;
                result_next.hit_count      = '0;
                result_next.miss_count     = '0;
                result_next.update_count   = '0;
                result_next.eviction_count = '0;
            end
            KIND_RESOLVE:
            begin
                result_next.slot = SLOT_W'(target);
                if (match_found_reg && match_ceq_reg)
                begin
                    result_next.status    = ST_HIT;
                    result_next.hit_count = sat_inc(hits_reg);
                end
                else if (match_found_reg)
                begin
                    result_next.status       = ST_UPDATE;
                    result_next.miss_count   = sat_inc(misses_reg);
                    result_next.update_count = sat_inc(updates_reg);
                end
                else
                begin
                    result_next.status     = ST_INSERT;
                    result_next.miss_count = sat_inc(misses_reg);
                    if (do_evict)
                    begin
                        result_next.evicted        = 1'b1;
                        result_next.eviction_count = sat_inc(evicts_reg);
                    end
                    else
                    begin
                        result_next.entry_count = FILL_OUT_W'(fill_reg + 1'b1);
                    end
                end
            end
            default:
            begin
                result_next.status = ST_REJECT;
            end
        endcase
    end

    // Result payload, loaded only when the output register is free
    always_ff @(posedge clk)
    begin
        if (finish)
        begin
            result_reg <= result_next;
        end
    end

endmodule

`default_nettype wire

// ===== design/vlpc_checker.sv =====
// ---------------------------------------------------------------------------
// vlpc_checker: port-level checks for the placement cache
// Watches the top-level ports and is bound to the top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module vlpc_checker (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          out_valid,
    input  wire logic                          out_stall,
    input  wire logic [vlpc_pkg::STATUS_W-1:0] status,
    input  wire logic [vlpc_pkg::SLOT_W-1:0]   slot,
    input  wire logic                          evicted,
    input  wire logic [vlpc_pkg::FILL_OUT_W-1:0] entry_count,
    input  wire logic [vlpc_pkg::CNT32_W-1:0]  hit_count,
    input  wire logic [vlpc_pkg::CNT32_W-1:0]  miss_count
);
    import vlpc_pkg::*;

    // A stalled result word holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(status) && $stable(hit_count))
        else $error("result changed while stalled");

    // Clear reports an empty table and zero hit and miss counters
    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_CLEAR |-> entry_count == '0 && hit_count == '0
            && miss_count == '0)
        else $error("clear result not empty");

    // Rejects and clears carry no slot and no eviction
    a_noslot: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_REJECT || status == ST_CLEAR) |-> slot == '0 && !evicted)
        else $error("slot or evict on reject/clear");

    // Only an insert may evict
    a_evict: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && evicted |-> status == ST_INSERT)
        else $error("eviction without insert");

endmodule

bind versioned_lru_placement_cache vlpc_checker u_vlpc_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .slot        (slot),
    .evicted     (evicted),
    .entry_count (entry_count),
    .hit_count   (hit_count),
    .miss_count  (miss_count)
);

`default_nettype wire

// ===== dv/versioned_lru_placement_cache_test.sv =====
// ---------------------------------------------------------------------------
// versioned_lru_placement_cache_test: self-checking bench for the LRU cache
// Drives directed rows and then random request words through the
// valid/stall channels, with random gaps and stalls on both sides. Every
// result word is checked field by field against an in-bench cache model.
// Capacity is rewritten over the APB port between phases while idle.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module versioned_lru_placement_cache_test;
    import vlpc_pkg::*;

    localparam int NSLOT = 16;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [PDATA_W-1:0] pwdata = '0;
    logic [PDATA_W-1:0] prdata;
    logic pready;
    logic in_valid = 1'b0;
    logic in_stall;
    logic mode = 1'b0;
    logic [KEY_W-1:0] identity = '0, transform_version = '0, content_version = '0;
    logic [FRAME_W-1:0] frame_number = '0;
    logic has_anchors = 1'b0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0] slot;
    logic evicted;
    logic [FILL_OUT_W-1:0] entry_count;
    logic [CNT32_W-1:0] hit_count, miss_count, update_count, eviction_count;

    versioned_lru_placement_cache dut (.*);

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    typedef struct {
        logic              mode;
        logic [KEY_W-1:0]  id;
        logic [KEY_W-1:0]  tr;
        logic [KEY_W-1:0]  cv;
        logic [FRAME_W-1:0] fr;
        logic              anc;
    } request_t;

    // Cache model state
    bit                 m_valid [NSLOT];
    logic [KEY_W-1:0]   m_id [NSLOT];
    logic [KEY_W-1:0]   m_tr [NSLOT];
    logic [KEY_W-1:0]   m_cv [NSLOT];
    logic [FRAME_W-1:0] m_fr [NSLOT];
    logic [CNT32_W-1:0] m_hits, m_misses, m_updates, m_evicts;
    logic [CAP_W-1:0]   m_capacity = CAP_RESET;

    result_t expected_words[$];
    int mismatches = 0;

    function automatic logic [CNT32_W-1:0] bump(input logic [CNT32_W-1:0] x);
        return (x == 32'hFFFF_FFFF) ? x : x + 32'd1;
    endfunction

    function automatic result_t resolve_model(input request_t q);
        result_t r;
        int match, target, fill, cap;
        r = '0;
        r.status = ST_REJECT;
        match = -1;
        target = -1;
        if (q.mode)
        begin
            foreach (m_valid[i]) m_valid[i] = 0;
            m_hits = 0; m_misses = 0; m_updates = 0; m_evicts = 0;
            r.status = ST_CLEAR;
        end
        else if (q.id != 0 && q.cv != 0 && q.anc)
        begin
            for (int i = 0; i < NSLOT; i++)
                if (match < 0 && m_valid[i] && m_id[i] == q.id && m_tr[i] == q.tr)
                    match = i;
            if (match >= 0 && m_cv[match] == q.cv)
            begin
                m_fr[match] = q.fr;
                m_hits = bump(m_hits);
                r.status = ST_HIT;
                r.slot = match[SLOT_W-1:0];
            end
            else if (match >= 0)
            begin
                m_misses = bump(m_misses);
                m_updates = bump(m_updates);
                m_cv[match] = q.cv;
                m_fr[match] = q.fr;
                r.status = ST_UPDATE;
                r.slot = match[SLOT_W-1:0];
            end
            else
            begin
                cap = m_capacity;
                if (cap == 0) cap = 1;
                if (cap > NSLOT) cap = NSLOT;
                m_misses = bump(m_misses);
                fill = 0;
                foreach (m_valid[i]) fill += m_valid[i];
                if (fill >= cap)
                begin
                    for (int i = 0; i < NSLOT; i++)
                        if (m_valid[i] && (target < 0 || m_fr[i] < m_fr[target]))
                            target = i;
                    if (target >= 0)
                    begin
                        m_evicts = bump(m_evicts);
                        r.evicted = 1'b1;
                    end
                end
                for (int i = 0; i < NSLOT; i++)
                    if (target < 0 && !m_valid[i])
                        target = i;
                if (target < 0) target = 0;
                m_valid[target] = 1;
                m_id[target] = q.id;
                m_tr[target] = q.tr;
                m_cv[target] = q.cv;
                m_fr[target] = q.fr;
                r.status = ST_INSERT;
                r.slot = target[SLOT_W-1:0];
            end
        end
        fill = 0;
        foreach (m_valid[i]) fill += m_valid[i];
        r.entry_count = fill[FILL_OUT_W-1:0];
        r.hit_count = m_hits;
        r.miss_count = m_misses;
        r.update_count = m_updates;
        r.eviction_count = m_evicts;
        return r;
    endfunction

    task automatic report_mismatch(input string field, input logic [63:0] got,
                                   input logic [63:0] want);
        mismatches++;
        $display("mismatch %s: got %0h want %0h at %0t", field, got, want, $realtime);
    endtask

    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 50) return 0;
        if (p < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Sink: random stall runs, compare each accepted word with the oldest one due
    bit stall_free = 0;
    int stall_left = 0;
    always @(posedge clk)
    begin
        result_t w;
        if (out_valid && !out_stall)
        begin
            if (expected_words.size() == 0)
                report_mismatch("unexpected word", {61'd0, status}, 64'd0);
            else
            begin
                w = expected_words.pop_front();
                if (status !== w.status) report_mismatch("status", status, w.status);
                if (slot !== w.slot) report_mismatch("slot", slot, w.slot);
                if (evicted !== w.evicted) report_mismatch("evicted", evicted, w.evicted);
                if (entry_count !== w.entry_count)
                    report_mismatch("entry_count", entry_count, w.entry_count);
                if (hit_count !== w.hit_count)
                    report_mismatch("hit_count", hit_count, w.hit_count);
                if (miss_count !== w.miss_count)
                    report_mismatch("miss_count", miss_count, w.miss_count);
                if (update_count !== w.update_count)
                    report_mismatch("update_count", update_count, w.update_count);
                if (eviction_count !== w.eviction_count)
                    report_mismatch("eviction_count", eviction_count, w.eviction_count);
            end
        end
        if (stall_free)
        begin
            out_stall <= 1'b0;
            stall_left = 0;
        end
        else if (stall_left > 0)
        begin
            out_stall <= 1'b1;
            stall_left--;
        end
        else
        begin
            out_stall <= 1'b0;
            stall_left = gap_len();
        end
    end

    // Send one request word; valid stays high into the next word when no gap
    task automatic send_request(input request_t q);
        int g;
        g = gap_len();
        if (g > 0)
        begin
            in_valid <= 1'b0;
            if ($urandom_range(0, 1)) identity <= {$urandom, $urandom};
            repeat (g) @(posedge clk);
        end
        in_valid <= 1'b1;
        mode <= q.mode;
        identity <= q.id;
        transform_version <= q.tr;
        content_version <= q.cv;
        frame_number <= q.fr;
        has_anchors <= q.anc;
        expected_words = {expected_words, resolve_model(q)};
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (expected_words.size() != 0) @(posedge clk);
        repeat (30) @(posedge clk);
    endtask

    task automatic write_capacity(input logic [CAP_W-1:0] v);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= {REG_CAPACITY, 2'b00};
        pwdata <= {$urandom_range(0, 1) ? 27'h7FF_FFFF : 27'd0, v};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        m_capacity = v;
        @(posedge clk);
    endtask

    function automatic request_t rq(input logic md, input logic [63:0] id, tr, cv,
                                    input logic [31:0] fr, input logic anc);
        request_t q;
        q.mode = md; q.id = id; q.tr = tr; q.cv = cv; q.fr = fr; q.anc = anc;
        return q;
    endfunction

    // Random request drawn from a small key pool so hits and updates happen
    function automatic request_t random_request(input int pool);
        request_t q;
        int p;
        p = $urandom_range(0, 99);
        q.mode = (p < 2);
        q.id = ($urandom_range(0, 9) == 0) ? {$urandom, $urandom}
                                            : 64'(($urandom_range(1, pool)) << 56 | 64'h5);
        q.tr = ($urandom_range(0, 9) == 0) ? {$urandom, $urandom}
                                            : 64'($urandom_range(0, 1)) << 63;
        q.cv = ($urandom_range(0, 9) == 0) ? {$urandom, $urandom}
                                            : 64'($urandom_range(1, 3));
        q.fr = ($urandom_range(0, 19) == 0) ? $urandom : $urandom_range(0, 40);
        q.anc = 1'b1;
        if (p >= 2 && p < 8)
        begin
            case ($urandom_range(0, 2))
                0: q.id = '0;
                1: q.cv = '0;
                default: q.anc = 1'b0;
            endcase
        end
        return q;
    endfunction

    // Directed rows: expected word typed in where obvious (zero = use model)
    typedef struct {
        request_t q;
        bit       typed;
        status_t  st;
        int       cnt;
    } row_t;

    function automatic row_t mk_row(input request_t q, input bit typed,
                                    input status_t st, input int cnt);
        row_t r;
        r.q = q; r.typed = typed; r.st = st; r.cnt = cnt;
        return r;
    endfunction

    initial
    begin
        row_t rows[$];
        result_t w;
        int caps[6] = '{16, 1, 3, 0, 31, 8};
        foreach (m_valid[i]) m_valid[i] = 0;
        m_hits = 0; m_misses = 0; m_updates = 0; m_evicts = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        rows = {rows, mk_row(rq(0, '1, '1, '1, '1, 1), 1, ST_INSERT, 1)};
        rows = {rows, mk_row(rq(0, '1, '1, '1, 0, 1), 1, ST_HIT, 1)};
        rows = {rows, mk_row(rq(0, '1, '1, 64'd1, 5, 1), 1, ST_UPDATE, 1)};
        rows = {rows, mk_row(rq(0, 0, 1, 1, 1, 1), 1, ST_REJECT, 1)};
        rows = {rows, mk_row(rq(0, 1, 1, 0, 1, 1), 1, ST_REJECT, 1)};
        rows = {rows, mk_row(rq(0, 1, 1, 1, 1, 0), 1, ST_REJECT, 1)};
        rows = {rows, mk_row(rq(0, 1, 0, 1, 0, 1), 1, ST_INSERT, 2)};
        rows = {rows, mk_row(rq(0, 1, 1, 1, 0, 1), 1, ST_INSERT, 3)};
        rows = {rows, mk_row(rq(0, 1, 0, 2, 9, 1), 0, ST_REJECT, 0)};
        rows = {rows, mk_row(rq(1, '1, '1, '1, '1, 1), 1, ST_CLEAR, 0)};
        for (int i = 0; i < 17; i++)
            rows = {rows, mk_row(rq(0, 64'(i + 7), 0, 1, 32'(100 - i), 1), 0, ST_REJECT, 0)};
        foreach (rows[i])
        begin
            send_request(rows[i].q);
            if (rows[i].typed)
            begin
                w = expected_words[$];
                if (w.status != rows[i].st || w.entry_count != rows[i].cnt)
                    report_mismatch("directed table row", 64'(i), 64'(w.status));
                w.status = rows[i].st;
                w.entry_count = FILL_OUT_W'(rows[i].cnt);
                expected_words[$] = w;
            end
        end
        drain();

        // Random phases across capacity settings, including the extremes
        foreach (caps[c])
        begin
            write_capacity(CAP_W'(caps[c]));
            for (int n = 0; n < 190; n++)
            begin
                send_request(random_request(c == 2 ? 4 : 24));
                if (n == 95)
                begin
                    // hold off until everything sent so far has come back
                    in_valid <= 1'b0;
                    @(posedge clk);
                    while (expected_words.size() != 0) @(posedge clk);
                    stall_free = (c % 2 == 0);
                end
            end
            stall_free = 0;
            drain();
        end

        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial
    begin
        #3_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule

// ===== filelist.f =====
design/vlpc_pkg.sv
design/vlpc_ram.sv
design/vlpc_front.sv
design/vlpc_back.sv
design/versioned_lru_placement_cache.sv
design/vlpc_checker.sv
dv/versioned_lru_placement_cache_test.sv
